// File: hdl/srfifo_pkg.sv
// ----------------------------------------------------------------------------
// srfifo_pkg
// Types, codes and ring-slot arithmetic shared by the searchable reversible
// queue: word and index types, command and status codes, storage control.
// ----------------------------------------------------------------------------
`default_nettype none

package srfifo_pkg;

    // Ring size and derived widths
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic signed [31:0]  t_word;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_count;

    localparam t_count            DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(DEPTH);

    typedef enum logic [2:0] {
        CMD_ENQ  = 3'd0,
        CMD_DEQ  = 3'd1,
        CMD_SRCH = 3'd2,
        CMD_MAX  = 3'd3,
        CMD_REV  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_PUSH
    } t_state;

    // Storage port control: one write and one read, by logical position
    typedef struct packed {
        logic  wr_en;
        t_addr wr_pos;
        t_word wr_data;
        logic  rd_en;
        t_addr rd_pos;
        t_addr head;
        logic  rev;
    } t_store_ctl;

    // Map a logical position (0 = front) to a ring slot
    function automatic t_addr slot_of(t_addr head, logic rev, t_addr pos);
        logic [ADDR_W:0] s;
        if (rev) begin
            if (head >= pos) begin
                s = {1'b0, head} - {1'b0, pos};
            end else begin
                s = {1'b0, head} + DEPTH_X - {1'b0, pos};
            end
        end else begin
            s = {1'b0, head} + {1'b0, pos};
            if (s >= DEPTH_X) begin
                s = s - DEPTH_X;
            end
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/srfifo_in_if.sv
// ----------------------------------------------------------------------------
// srfifo_in_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface srfifo_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] value;
    logic signed [31:0] new_value;

    modport source (output valid, output command, output value, output new_value,
                    input ready);
    modport sink   (input valid, input command, input value, input new_value,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/srfifo_out_if.sv
// ----------------------------------------------------------------------------
// srfifo_out_if
// Result channel: valid/ready handshake carrying status and result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface srfifo_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

`default_nettype wire

// File: hdl/searchable_reversible_fifo_top.sv
// ----------------------------------------------------------------------------
// searchable_reversible_fifo_top
// Bounded queue of signed words with enqueue, dequeue, search-and-update,
// maximum and order reversal, run one command at a time by a small sequencer.
// ----------------------------------------------------------------------------
// One command word is taken at a time and yields exactly one result word.
// Enqueue, reverse and unused codes go from decode straight to the result
// hand-off, as do commands that fail on an empty or full queue. Dequeue
// passes through the walk state just to read the front word. Search-and-update
// and maximum walk the stored words front to back through the single read
// port of the ring storage and one shared compare unit, one word per cycle,
// up to all 16 words of a full queue; search stops at the first match.
// The next command is taken as soon as the previous result has moved into the
// output register, even while that result still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_reversible_fifo_top
    import srfifo_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    srfifo_in_if.sink    i_in,
    srfifo_out_if.source o_out
);

    t_state     r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    t_word      r_val, n_val;
    t_word      r_repl, n_repl;
    t_addr      r_head, n_head;
    t_count     r_count, n_count;
    logic       r_rev, n_rev;
    t_count     r_pos, n_pos;
    t_addr      r_dpos, n_dpos;
    t_word      r_best, n_best;
    t_status    r_stat, n_stat;
    t_word      r_res, n_res;
    logic       r_ovld, n_ovld;
    t_status    r_ostat, n_ostat;
    t_word      r_ores, n_ores;

    t_store_ctl store_ctl;
    t_word      rd_data;
    logic       cmp_eq;
    logic       cmp_gt;
    logic       scan_last;
    logic       scan_done;
    logic       start_scan;
    logic       out_free;
    t_word      best_now;

    srfifo_store u_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .o_rd_data (rd_data)
    );

    // Shared compare unit: key match and running maximum
    assign cmp_eq   = (rd_data == r_val);
    assign cmp_gt   = (rd_data > r_best);
    assign best_now = ((r_dpos == '0) || cmp_gt) ? rd_data : r_best;

    // Walk control
    assign scan_last  = (r_pos == r_count);
    assign start_scan = (r_cmd inside {CMD_DEQ, CMD_SRCH, CMD_MAX}) && (r_count != '0);
    always_comb begin
        case (r_cmd)
            CMD_SRCH: scan_done = cmp_eq || scan_last;
            CMD_MAX:  scan_done = scan_last;
            default:  scan_done = 1'b1;
        endcase
    end

    assign out_free = !r_ovld || o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = start_scan ? S_SCAN : S_PUSH;
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and storage control
    always_comb begin
        n_cmd   = r_cmd;
        n_val   = r_val;
        n_repl  = r_repl;
        n_head  = r_head;
        n_count = r_count;
        n_rev   = r_rev;
        n_pos   = r_pos;
        n_dpos  = r_dpos;
        n_best  = r_best;
        n_stat  = r_stat;
        n_res   = r_res;
        n_ostat = r_ostat;
        n_ores  = r_ores;
        n_ovld  = o_out.ready ? 1'b0 : r_ovld;

        store_ctl.wr_en   = 1'b0;
        store_ctl.wr_pos  = r_count[ADDR_W-1:0];
        store_ctl.wr_data = r_val;
        store_ctl.rd_en   = 1'b0;
        store_ctl.rd_pos  = r_pos[ADDR_W-1:0];
        store_ctl.head    = r_head;
        store_ctl.rev     = r_rev;

        case (r_state)
            // Latch the command word
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd  = t_cmd'(i_in.command);
                    n_val  = i_in.value;
                    n_repl = i_in.new_value;
                end
            end
            // Decode and run the single-step part
            S_START: begin
                n_stat = ST_OK;
                n_res  = '0;
                n_pos  = CNT_W'(1);
                n_dpos = '0;
                store_ctl.rd_pos = '0;
                case (r_cmd)
                    CMD_ENQ: begin
                        if (r_count == DEPTH_CNT) begin
                            n_stat = ST_FULL;
                        end else begin
                            store_ctl.wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    CMD_DEQ, CMD_MAX: begin
                        if (r_count == '0) begin
                            n_stat = ST_EMPTY;
                        end else begin
                            store_ctl.rd_en = 1'b1;
                        end
                    end
                    CMD_SRCH: begin
                        if (r_count == '0) begin
                            n_stat = ST_NOT_FOUND;
                        end else begin
                            store_ctl.rd_en = 1'b1;
                        end
                    end
                    CMD_REV: begin
                        if (r_count != '0) begin
                            n_head = slot_of(r_head, r_rev, ADDR_W'(r_count - 1'b1));
                        end
                        n_rev = ~r_rev;
                    end
                    default: ;
                endcase
            end
            // Consume one stored word per cycle
            S_SCAN: begin
                case (r_cmd)
                    CMD_DEQ: begin
                        n_res   = rd_data;
                        n_head  = slot_of(r_head, r_rev, ADDR_W'(1));
                        n_count = r_count - 1'b1;
                    end
                    CMD_SRCH: begin
                        if (cmp_eq) begin
                            store_ctl.wr_en   = 1'b1;
                            store_ctl.wr_pos  = r_dpos;
                            store_ctl.wr_data = r_repl;
                        end else if (scan_last) begin
                            n_stat = ST_NOT_FOUND;
                        end
                    end
                    CMD_MAX: begin
                        n_best = best_now;
                        if (scan_last) begin
                            n_res = best_now;
                        end
                    end
                    default: ;
                endcase
                // Advance to the next stored word
                if (!scan_done) begin
                    store_ctl.rd_en = 1'b1;
                    n_pos  = r_pos + 1'b1;
                    n_dpos = r_pos[ADDR_W-1:0];
                end
            end
            // Hand the result to the output register
            S_PUSH: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_ostat = r_stat;
                    n_ores  = r_res;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_ovld  <= n_ovld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_repl  <= n_repl;
        r_pos   <= n_pos;
        r_dpos  <= n_dpos;
        r_best  <= n_best;
        r_stat  <= n_stat;
        r_res   <= n_res;
        r_ostat <= n_ostat;
        r_ores  <= n_ores;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovld;
    assign o_out.status       = r_ostat;
    assign o_out.result_value = r_ores;

    // Fill count never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("fill count beyond ring size");

    // A walk only runs over stored words
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (t_count'(r_dpos) < r_count))
        else $error("walk position outside stored words");

    // Enqueue into a queue with room adds one word
    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && r_cmd == CMD_ENQ && r_count != DEPTH_CNT)
        |=> (r_count == t_count'($past(r_count) + 1'b1)))
        else $error("enqueue did not add a word");

    // A walk always ends in the hand-off state
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_done) |=> (r_state == S_PUSH))
        else $error("walk did not finish into hand-off");

endmodule

`default_nettype wire

// File: hdl/srfifo_store.sv
// ----------------------------------------------------------------------------
// srfifo_store
// Ring storage of the queue. Translates logical positions into ring slots
// using head and direction, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srfifo_store
    import srfifo_pkg::*;
(
    input  wire             i_clk,
    input  wire t_store_ctl i_ctl,
    output t_word           o_rd_data
);

    t_word r_mem [DEPTH];
    t_word r_rd_data;
    t_addr wr_slot;
    t_addr rd_slot;

    // Resolve ring slots
    assign wr_slot = slot_of(i_ctl.head, i_ctl.rev, i_ctl.wr_pos);
    assign rd_slot = slot_of(i_ctl.head, i_ctl.rev, i_ctl.rd_pos);

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[wr_slot] <= i_ctl.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_slot];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: test/searchable_reversible_fifo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_reversible_fifo_top_tb
// Self-checking bench for the searchable reversible queue. A mirror of the
// queue (ring, head, fill, direction) predicts the reply to every accepted
// command word; each reply word is compared against the oldest prediction.
// Directed words cover empty and full cases and extreme values, then
// fill/drain-biased random traffic runs under several idle and stall mixes,
// plus a long receiver hold-off that backs up the command channel.
// ----------------------------------------------------------------------------
module searchable_reversible_fifo_top_tb
    import srfifo_pkg::*;
();

    localparam int         CLK_HALF        = 6;
    localparam int         RESET_CYCLES    = 7;
    localparam int         STALL_LIMIT     = 1000;
    localparam int         DRAIN_CYCLES    = 40;
    localparam int         HOLD_OFF_CYCLES = 150;
    localparam int         PHASE_WORDS     = 500;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam t_word      WORD_MIN        = t_word'(32'h8000_0000);
    localparam t_word      WORD_MAX        = t_word'(32'h7fff_ffff);
    localparam t_word      ABSENT_KEY      = t_word'(32'h1234_5678);

    typedef struct packed {
        t_status status;
        t_word   value;
    } t_reply;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    srfifo_in_if  cmd_ch ();
    srfifo_out_if reply_ch ();

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;
    int error_count    = 0;

    t_reply replies_due [$];

    // Mirror of the queue contents and pointers
    t_word  ring_words [DEPTH];
    t_addr  ring_head;
    t_count ring_fill;
    logic   ring_reversed;

    searchable_reversible_fifo_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (reply_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Ring slot of logical position pos, 0 being the front
    function automatic t_addr ring_slot(int pos);
        int s;
        if (ring_reversed) begin
            s = (int'(ring_head) + DEPTH - pos) % DEPTH;
        end else begin
            s = (int'(ring_head) + pos) % DEPTH;
        end
        return t_addr'(s);
    endfunction

    // Apply one command to the mirror and return the reply it must produce
    function automatic t_reply apply_command(logic [2:0] command, t_word value,
                                             t_word new_value);
        t_reply r;
        t_addr  slot;
        t_word  best;
        r.status = ST_OK;
        r.value  = '0;
        case (command)
            CMD_ENQ: begin
                if (ring_fill >= DEPTH_CNT) begin
                    r.status = ST_FULL;
                end else begin
                    ring_words[ring_slot(int'(ring_fill))] = value;
                    ring_fill = ring_fill + 1'b1;
                end
            end
            CMD_DEQ: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value   = ring_words[ring_slot(0)];
                    ring_head = ring_slot(1);
                    ring_fill = ring_fill - 1'b1;
                end
            end
            CMD_SRCH: begin
                // overwrite only the first match counted from the front
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < int'(ring_fill); i++) begin
                    slot = ring_slot(i);
                    if (r.status == ST_NOT_FOUND && ring_words[slot] == value) begin
                        ring_words[slot] = new_value;
                        r.status = ST_OK;
                    end
                end
            end
            CMD_MAX: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    best = ring_words[ring_slot(0)];
                    for (int i = 1; i < int'(ring_fill); i++) begin
                        if (ring_words[ring_slot(i)] > best) begin
                            best = ring_words[ring_slot(i)];
                        end
                    end
                    r.value = best;
                end
            end
            CMD_REV: begin
                // old rear becomes the new front
                if (ring_fill != 0) begin
                    ring_head = ring_slot(int'(ring_fill) - 1);
                end
                ring_reversed = ~ring_reversed;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Often small words (-8 to 7) so that duplicates and search hits are common
    function automatic t_word pick_word();
        case ($urandom_range(9))
            0:          return WORD_MIN;
            1:          return WORD_MAX;
            2, 3, 4, 5: return t_word'($urandom_range(15)) - 8;
            default:    return t_word'($urandom);
        endcase
    endfunction

    // Search keys: half the time a word that is stored right now
    function automatic t_word pick_key();
        if (ring_fill != 0 && $urandom_range(1) == 1) begin
            return ring_words[ring_slot($urandom_range(int'(ring_fill) - 1))];
        end
        return pick_word();
    endfunction

    function automatic logic [2:0] pick_command(t_mix mix);
        int roll;
        int enq_pct;
        int deq_pct;
        roll    = $urandom_range(99);
        enq_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 35;
        deq_pct = (mix == MIX_FILL) ? 10 : (mix == MIX_DRAIN) ? 55 : 30;
        if (roll < enq_pct) begin
            return CMD_ENQ;
        end
        roll = roll - enq_pct;
        if (roll < deq_pct) begin
            return CMD_DEQ;
        end
        roll = roll - deq_pct;
        if (roll < 12) begin
            return CMD_SRCH;
        end else if (roll < 20) begin
            return CMD_MAX;
        end else if (roll < 25) begin
            return CMD_REV;
        end
        return 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    endfunction

    // Offer one command word; called and returning just after a falling edge
    task automatic send_command(logic [2:0] command, t_word value, t_word new_value);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= command;
        cmd_ch.value     <= value;
        cmd_ch.new_value <= new_value;
        @(posedge i_clk);
        while (!cmd_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Hold valid low until every predicted reply has arrived
    task automatic wait_replies_done();
        cmd_ch.valid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_command(CMD_DEQ, '0, '0);
        send_command(CMD_MAX, '0, '0);
        send_command(CMD_SRCH, '0, WORD_MAX);
        send_command(CMD_REV, '0, '0);
        send_command(CMD_SPARE_FIRST, WORD_MAX, WORD_MIN);
        send_command(CMD_SPARE_LAST, WORD_MIN, WORD_MAX);
    endtask

    task automatic test_fill_and_extremes();
        send_command(CMD_ENQ, WORD_MIN, '0);
        send_command(CMD_ENQ, WORD_MAX, '0);
        send_command(CMD_ENQ, '0, '0);
        send_command(CMD_ENQ, -1, '0);
        for (int i = 4; i < DEPTH; i++) begin
            send_command(CMD_ENQ, t_word'(i) - 8, '0);
        end
        // push into a full queue, then walk the whole ring
        send_command(CMD_ENQ, WORD_MAX, '0);
        send_command(CMD_MAX, '0, '0);
        send_command(CMD_SRCH, WORD_MIN, WORD_MAX);
        send_command(CMD_SRCH, ABSENT_KEY, '0);
        send_command(CMD_REV, '0, '0);
        send_command(CMD_DEQ, '0, '0);
    endtask

    task automatic test_random(int word_count, int idle_pct, int stall_pct);
        t_mix       mix;
        int         left_in_mix;
        logic [2:0] command;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        mix            = MIX_EVEN;
        left_in_mix    = 0;
        for (int n = 0; n < word_count; n++) begin
            // switch between filling, draining and balanced traffic
            if (left_in_mix == 0) begin
                mix         = t_mix'($urandom_range(2));
                left_in_mix = $urandom_range(60, 20);
            end
            left_in_mix--;
            command = pick_command(mix);
            send_command(command, (command == CMD_SRCH) ? pick_key() : pick_word(),
                         pick_word());
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        // block the reply side and keep offering words until input stalls
        @(posedge i_clk);
        sink_hold_left = HOLD_OFF_CYCLES;
        @(negedge i_clk);
        for (int n = 0; n < 24; n++) begin
            send_command(pick_command(MIX_EVEN), pick_word(), pick_word());
        end
        wait_replies_done();
        for (int n = 0; n < 8; n++) begin
            send_command(pick_command(MIX_FILL), pick_word(), pick_word());
        end
    endtask

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (sink_hold_left > 0) begin
            reply_ch.ready <= 1'b0;
            sink_hold_left--;
        end else begin
            reply_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Check each reply word, then predict the reply of an accepted command
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if (reply_ch.valid && reply_ch.ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply: status %0d result_value %0d",
                           reply_ch.status, reply_ch.result_value);
                    error_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (reply_ch.status !== want.status) begin
                        $error("status: expected %0d actual %0d",
                               want.status, reply_ch.status);
                        error_count++;
                    end
                    if (reply_ch.result_value !== want.value) begin
                        $error("result_value: expected %0d actual %0d",
                               want.value, reply_ch.result_value);
                        error_count++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                replies_due.push_back(apply_command(cmd_ch.command, cmd_ch.value,
                                                    cmd_ch.new_value));
            end
        end
    end

    // Watchdog: end the run after too many cycles without any handshake
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) ||
                (reply_ch.valid && reply_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("searchable_reversible_fifo_top_tb NOT OK");
        $finish;
    end

    initial begin
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_ENQ;
        cmd_ch.value     = '0;
        cmd_ch.new_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            ring_words[i] = '0;
        end
        ring_head     = '0;
        ring_fill     = '0;
        ring_reversed = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_extremes();
        test_random(PHASE_WORDS, 0, 0);
        test_random(PHASE_WORDS, 63, 0);
        test_backpressure();
        test_random(PHASE_WORDS, 0, 63);
        test_random(PHASE_WORDS, 8, 8);

        // drain, then leave room for any stray reply
        wait_replies_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("searchable_reversible_fifo_top_tb OK");
        end else begin
            $display("searchable_reversible_fifo_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/srfifo_pkg.sv
hdl/srfifo_in_if.sv
hdl/srfifo_out_if.sv
hdl/srfifo_store.sv
hdl/searchable_reversible_fifo_top.sv
test/searchable_reversible_fifo_top_tb.sv
